[sv/gdsc_pkg.sv]
package gdsc_pkg;

    // Largest year accepted in either direction.
    localparam int unsigned MAX_YEAR = 9999;

    // Serial of 31 December of MAX_YEAR; a larger serial is out of range.
    localparam logic [22:0] SERIAL_LIMIT = 23'(MAX_YEAR * 365 + MAX_YEAR / 4
                                               - MAX_YEAR / 100 + MAX_YEAR / 400);

    // Number of conditional-subtract stages in the serial to date divider.
    localparam int unsigned NUM_STEPS = 14;

    localparam logic [3:0] MONTH_FEB = 4'd2;
    localparam logic [3:0] MONTH_DEC = 4'd12;

    typedef struct packed {
        logic        mode;
        logic [4:0]  day_in;
        logic [3:0]  month_in;
        logic [13:0] year_in;
        logic [21:0] serial_in;
    } t_in_item;

    typedef struct packed {
        logic [21:0] serial_out;
        logic [4:0]  day_out;
        logic [3:0]  month_out;
        logic [13:0] year_out;
        logic        range_error;
    } t_out_item;

    // Item state that travels down the divider chain.
    typedef struct packed {
        logic        vld;
        logic        mode;
        logic        err;
        logic [21:0] ser;
        logic [21:0] rem;
        logic [13:0] yacc;
        logic [13:0] taken;
    } t_pipe;

    // Length of a month in a common year; zero for a code that is no month.
    function automatic logic [4:0] month_len(input logic [3:0] m);
        logic [4:0] len;
        unique case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
            4'd2:                                       len = 5'd28;
            default:                                    len = 5'd0;
        endcase
        return len;
    endfunction

    // Days in a common year before the first of month m.
    function automatic logic [8:0] cum_days(input logic [3:0] m);
        logic [8:0] c;
        unique case (m)
            4'd2:    c = 9'd31;
            4'd3:    c = 9'd59;
            4'd4:    c = 9'd90;
            4'd5:    c = 9'd120;
            4'd6:    c = 9'd151;
            4'd7:    c = 9'd181;
            4'd8:    c = 9'd212;
            4'd9:    c = 9'd243;
            4'd10:   c = 9'd273;
            4'd11:   c = 9'd304;
            4'd12:   c = 9'd334;
            default: c = 9'd0;
        endcase
        return c;
    endfunction

    // Divisor of each divider step: five for 400-year cycles, two for
    // centuries, five for 4-year cycles and two for single years.
    function automatic logic [21:0] step_div(input logic [3:0] k);
        logic [21:0] d;
        unique case (k)
            4'd0:    d = 22'd2337552;
            4'd1:    d = 22'd1168776;
            4'd2:    d = 22'd584388;
            4'd3:    d = 22'd292194;
            4'd4:    d = 22'd146097;
            4'd5:    d = 22'd73048;
            4'd6:    d = 22'd36524;
            4'd7:    d = 22'd23376;
            4'd8:    d = 22'd11688;
            4'd9:    d = 22'd5844;
            4'd10:   d = 22'd2922;
            4'd11:   d = 22'd1461;
            4'd12:   d = 22'd730;
            4'd13:   d = 22'd365;
            default: d = 22'd0;
        endcase
        return d;
    endfunction

    // Years that each divider step adds when it subtracts.
    function automatic logic [13:0] step_wt(input logic [3:0] k);
        logic [13:0] w;
        unique case (k)
            4'd0:    w = 14'd6400;
            4'd1:    w = 14'd3200;
            4'd2:    w = 14'd1600;
            4'd3:    w = 14'd800;
            4'd4:    w = 14'd400;
            4'd5:    w = 14'd200;
            4'd6:    w = 14'd100;
            4'd7:    w = 14'd64;
            4'd8:    w = 14'd32;
            4'd9:    w = 14'd16;
            4'd10:   w = 14'd8;
            4'd11:   w = 14'd4;
            4'd12:   w = 14'd2;
            4'd13:   w = 14'd1;
            default: w = 14'd0;
        endcase
        return w;
    endfunction

endpackage

[sv/gdsc_div_stage.sv]
module gdsc_div_stage (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [21:0]          i_div,
    input  logic [13:0]          i_wt,
    input  gdsc_pkg::t_pipe      i_stg,
    output gdsc_pkg::t_pipe      o_stg
);

    gdsc_pkg::t_pipe r_stg;
    gdsc_pkg::t_pipe n_stg;
    logic            w_ge;

    // One restoring step: subtract the divisor when it fits and record it.
    always_comb begin
        w_ge        = (i_stg.rem >= i_div);
        n_stg       = i_stg;
        n_stg.rem   = w_ge ? (i_stg.rem - i_div) : i_stg.rem;
        n_stg.yacc  = w_ge ? (i_stg.yacc + i_wt) : i_stg.yacc;
        n_stg.taken = {i_stg.taken[12:0], w_ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stg.vld <= 1'b0;
        end else begin
            r_stg <= n_stg;
        end
    end

    assign o_stg = r_stg;

endmodule

[sv/gregorian_date_serial_convert.sv]
// A result is marked by o_done as it leaves the output register.
// Throughput: one item per cycle; busy stays low, since nothing in the pipeline waits.
// The depth is set by the fourteen conditional-subtract stages of the serial divider.
// Reset (synchronous, active low) clears every valid bit; items in flight are dropped.
// The receiver cannot stall: each result is shown for exactly one cycle.
module gregorian_date_serial_convert (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    input  gdsc_pkg::t_in_item   i_item,
    output logic                 busy,
    output logic                 o_done,
    output gdsc_pkg::t_out_item  o_result
);

    // The pipeline never holds an item back, so the block is never busy.
    assign busy = 1'b0;

    // Input register stage.
    logic               r_in_vld;
    gdsc_pkg::t_in_item r_in;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else begin
            r_in_vld <= start && !busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_in <= i_item;
    end

    // Stage 1: divide the year and the year before it by 100 with a
    // reciprocal multiply (exact for values below 43699), and range-check
    // the serial for the reverse direction.
    logic        r_s1_vld;
    logic        r_s1_mode;
    logic [4:0]  r_s1_d;
    logic [3:0]  r_s1_m;
    logic [13:0] r_s1_y;
    logic [13:0] r_s1_p;
    logic [7:0]  r_s1_pq;
    logic [7:0]  r_s1_yq;
    logic [21:0] r_s1_r0;
    logic        r_s1_serr;

    logic [13:0] w_p;
    logic [26:0] w_pm;
    logic [26:0] w_ym;

    always_comb begin
        w_p  = r_in.year_in - 14'd1;
        w_pm = 27'(w_p) * 27'd5243;
        w_ym = 27'(r_in.year_in) * 27'd5243;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else begin
            r_s1_vld <= r_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_mode <= r_in.mode;
        r_s1_d    <= r_in.day_in;
        r_s1_m    <= r_in.month_in;
        r_s1_y    <= r_in.year_in;
        r_s1_p    <= w_p;
        r_s1_pq   <= w_pm[26:19];
        r_s1_yq   <= w_ym[26:19];
        r_s1_r0   <= r_in.serial_in - 22'd1;
        r_s1_serr <= (r_in.serial_in == 22'd0) ||
                     ({1'b0, r_in.serial_in} > gdsc_pkg::SERIAL_LIMIT);
    end

    // Stage 2: leap year, date validity, and the days in all earlier years
    // as 365 * p + p / 4 - p / 100 + p / 400.
    logic        r_s2_vld;
    logic        r_s2_mode;
    logic [4:0]  r_s2_d;
    logic [3:0]  r_s2_m;
    logic        r_s2_leap;
    logic        r_s2_ok;
    logic [22:0] r_s2_base;
    logic [21:0] r_s2_r0;
    logic        r_s2_serr;

    logic [13:0] w_ymod;
    logic        w_leap;
    logic [4:0]  w_len;
    logic        w_ok;
    logic [22:0] w_base;

    always_comb begin
        w_ymod = r_s1_y - 14'(r_s1_yq) * 14'd100;
        w_leap = (r_s1_y[1:0] == 2'd0) && ((w_ymod != 14'd0) || (r_s1_yq[1:0] == 2'd0));
        w_len  = gdsc_pkg::month_len(r_s1_m) +
                 5'((r_s1_m == gdsc_pkg::MONTH_FEB) && w_leap);
        w_ok   = (r_s1_m >= 4'd1) && (r_s1_m <= gdsc_pkg::MONTH_DEC) &&
                 (r_s1_y >= 14'd1) && (r_s1_y <= 14'(gdsc_pkg::MAX_YEAR)) &&
                 (r_s1_d >= 5'd1) && (r_s1_d <= w_len);
        w_base = 23'(r_s1_p) * 23'd365 + 23'(r_s1_p >> 2)
                 - 23'(r_s1_pq) + 23'(r_s1_pq >> 2);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else begin
            r_s2_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s2_mode <= r_s1_mode;
        r_s2_d    <= r_s1_d;
        r_s2_m    <= r_s1_m;
        r_s2_leap <= w_leap;
        r_s2_ok   <= w_ok;
        r_s2_base <= w_base;
        r_s2_r0   <= r_s1_r0;
        r_s2_serr <= r_s1_serr;
    end

    // Stage 3: finish the serial (add earlier months and the day) and load
    // the divider chain. A date whose serial does not fit 22 bits is an error.
    gdsc_pkg::t_pipe r_s3;
    gdsc_pkg::t_pipe n_s3;
    logic [22:0]     w_sum;

    always_comb begin
        w_sum = r_s2_base + 23'(gdsc_pkg::cum_days(r_s2_m))
                + 23'(r_s2_leap && (r_s2_m > gdsc_pkg::MONTH_FEB)) + 23'(r_s2_d);
        n_s3.vld   = r_s2_vld;
        n_s3.mode  = r_s2_mode;
        n_s3.err   = r_s2_mode ? r_s2_serr : (!r_s2_ok || w_sum[22]);
        n_s3.ser   = w_sum[21:0];
        n_s3.rem   = r_s2_r0;
        n_s3.yacc  = 14'd1;
        n_s3.taken = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3.vld <= 1'b0;
        end else begin
            r_s3 <= n_s3;
        end
    end

    // Divider chain: serial minus one is split into 400-year cycles,
    // centuries (at most three), 4-year cycles and years (at most three).
    // The year builds up as the steps subtract; the remainder left over is
    // the zero-based day of the year.
    gdsc_pkg::t_pipe w_chain [0:gdsc_pkg::NUM_STEPS];

    assign w_chain[0] = r_s3;

    for (genvar k = 0; k < gdsc_pkg::NUM_STEPS; k++) begin : g_div
        gdsc_div_stage u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_div   (gdsc_pkg::step_div(4'(k))),
            .i_wt    (gdsc_pkg::step_wt(4'(k))),
            .i_stg   (w_chain[k]),
            .o_stg   (w_chain[k + 1])
        );
    end

    // Leap year from the quotients: the year is divisible by 4 when the
    // last year of a 4-year cycle was reached, by 100 when that also falls
    // in the last 4-year cycle of a century, and by 400 when that century
    // is the last of its 400-year cycle.
    gdsc_pkg::t_pipe w_end;
    logic            w_div4;
    logic            w_div100;
    logic            w_div400;
    logic            w_end_leap;

    always_comb begin
        w_end      = w_chain[gdsc_pkg::NUM_STEPS];
        w_div4     = w_end.taken[1] && w_end.taken[0];
        w_div100   = w_div4 && w_end.taken[6] && w_end.taken[5] &&
                     !w_end.taken[4] && !w_end.taken[3] && !w_end.taken[2];
        w_div400   = w_div100 && w_end.taken[8] && w_end.taken[7];
        w_end_leap = w_div4 && (!w_div100 || w_div400);
    end

    // Month stage: the month is one plus the number of month starts that
    // lie at or below the day of the year.
    logic        r_m1_vld;
    logic        r_m1_mode;
    logic        r_m1_err;
    logic [21:0] r_m1_ser;
    logic [8:0]  r_m1_rem;
    logic        r_m1_leap;
    logic [13:0] r_m1_year;
    logic [3:0]  r_m1_month;

    logic [3:0]  w_cnt;
    logic [8:0]  w_thr;

    always_comb begin
        w_cnt = 4'd1;
        w_thr = '0;
        for (int k = 2; k <= 12; k++) begin
            w_thr = gdsc_pkg::cum_days(4'(k)) + 9'(w_end_leap && (k > 2));
            if (w_end.rem[8:0] >= w_thr) begin
                w_cnt = w_cnt + 4'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m1_vld <= 1'b0;
        end else begin
            r_m1_vld <= w_end.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_m1_mode  <= w_end.mode;
        r_m1_err   <= w_end.err;
        r_m1_ser   <= w_end.ser;
        r_m1_rem   <= w_end.rem[8:0];
        r_m1_leap  <= w_end_leap;
        r_m1_year  <= w_end.yacc;
        r_m1_month <= w_cnt;
    end

    // Day stage: subtract the start of the chosen month, then make it one-based.
    logic        r_m2_vld;
    logic        r_m2_mode;
    logic        r_m2_err;
    logic [21:0] r_m2_ser;
    logic [4:0]  r_m2_day;
    logic [13:0] r_m2_year;
    logic [3:0]  r_m2_month;

    logic [8:0]  w_day;

    always_comb begin
        w_day = r_m1_rem - gdsc_pkg::cum_days(r_m1_month)
                - 9'(r_m1_leap && (r_m1_month > gdsc_pkg::MONTH_FEB)) + 9'd1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m2_vld <= 1'b0;
        end else begin
            r_m2_vld <= r_m1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_m2_mode  <= r_m1_mode;
        r_m2_err   <= r_m1_err;
        r_m2_ser   <= r_m1_ser;
        r_m2_day   <= w_day[4:0];
        r_m2_year  <= r_m1_year;
        r_m2_month <= r_m1_month;
    end

    // Output register: only the fields of the selected direction are kept,
    // and an error clears them all but the flag.
    logic                r_done;
    gdsc_pkg::t_out_item r_result;
    gdsc_pkg::t_out_item n_result;

    always_comb begin
        n_result = '0;
        if (r_m2_err) begin
            n_result.range_error = 1'b1;
        end else if (r_m2_mode) begin
            n_result.day_out   = r_m2_day;
            n_result.month_out = r_m2_month;
            n_result.year_out  = r_m2_year;
        end else begin
            n_result.serial_out = r_m2_ser;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= r_m2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_result <= n_result;
    end

    assign o_done   = r_done;
    assign o_result = r_result;

endmodule
